// ===== rtl/krt_pkg.sv =====
// Shared types, sizes and codes of the keyed record table.
package krt_pkg;

   localparam int DEPTH      = 64;
   localparam int NAME_CHARS = 8;

   localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W    = $clog2(DEPTH + 1);
   localparam int NAME_BITS = NAME_CHARS * 8;
   localparam int OCC_W     = 7;

   localparam logic [63:0] NAME_MASK =
      (NAME_BITS >= 64) ? {64{1'b1}} : ((64'd1 << NAME_BITS) - 64'd1);

   // Request kinds carried in req_tuser.
   localparam logic [2:0] REQ_ADD    = 3'd0;
   localparam logic [2:0] REQ_DELETE = 3'd1;
   localparam logic [2:0] REQ_UPDATE = 3'd2;
   localparam logic [2:0] REQ_SEARCH = 3'd3;
   localparam logic [2:0] REQ_LIST   = 3'd4;

   // Result status carried in rsp_tuser.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic [31:0] amount;
      logic [63:0] name;
      logic [31:0] key;
   } record_type;

   typedef struct packed {
      logic             rotate;
      logic             compact;
      logic [IDX_W-1:0] gap_idx;
   } chain_ctl_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_WALK  = 4'b0010,
      S_SHIFT = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

endpackage

// ===== rtl/krt_cell.sv =====
// One storage cell of the record chain: holds a record and loads its neighbor's.
module krt_cell import krt_pkg::*; (
   input  logic       clock,
   input  logic       move,
   input  record_type rec_in,
   output record_type rec_out
);

   record_type rec_ff;
   record_type rec_next_in;

   always_comb begin
      rec_next_in = move ? rec_in : rec_ff;
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_next_in;
   end

   assign rec_out = rec_ff;

endmodule

// ===== rtl/krt_chain.sv =====
// Row of record cells that rotates toward cell 0 and closes gaps on delete.
module krt_chain import krt_pkg::*; (
   input  logic          clock,
   input  chain_ctl_type ctl,
   input  record_type    tail_in,
   output record_type    head
);

   record_type       rec  [DEPTH];
   record_type       din  [DEPTH];
   logic [DEPTH-1:0] mv;

   for (genvar p = 0; p < DEPTH; p++) begin : g_cell
      if (p == DEPTH - 1) begin : g_tail
         // The last cell keeps its stale record when a gap is closed.
         assign din[p] = tail_in;
         assign mv[p]  = ctl.rotate;
      end else begin : g_mid
         assign din[p] = rec[p+1];
         assign mv[p]  = ctl.rotate | (ctl.compact && (IDX_W'(p) >= ctl.gap_idx));
      end
      krt_cell u_cell (
         .clock   (clock),
         .move    (mv[p]),
         .rec_in  (din[p]),
         .rec_out (rec[p])
      );
   end

   assign head = rec[0];

endmodule

// ===== rtl/keyed_record_table.sv =====
// Top level of the keyed record table: request control, fill count and result register.
//
//  Channel | Direction | tdata (low bit up)                          | tuser    | tlast
//  req     | in        | key, name_tag, amount                       | req_type | -
//  rsp     | out       | rec_key, rec_name, rec_amount, occupancy    | status   | last
//
// Add, update and search walk one step per cell as the chain rotates a full turn
// past cell 0, then register the result. A delete that finds its key then closes
// the gap. A full add, an empty list and an unknown request go straight to the
// result. A list gives one result per walk step over the stored records and
// holds the walk while the result register is full.
// Reset is synchronous and clears the fill count, the state and rsp_tvalid.
module keyed_record_table import krt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // key, name_tag, amount
   input  logic [2:0]   req_tuser,   // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // rec_key, rec_name, rec_amount, occupancy, zero pad
   output logic [1:0]   rsp_tuser,   // status
   output logic         rsp_tlast    // last
);

   state_type        state_ff, state_in;
   logic [2:0]       op_ff, op_in;
   record_type       req_ff, req_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] gap_ff, gap_in;
   logic [1:0]       status_ff, status_in;
   record_type       res_ff, res_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   record_type       rsp_rec_ff, rsp_rec_in;
   logic [OCC_W-1:0] rsp_occ_ff, rsp_occ_in;
   logic             rsp_last_ff, rsp_last_in;

   record_type    head;
   record_type    tail_in;
   chain_ctl_type chain_ctl;

   logic accept;
   logic in_range;
   logic hit;
   logic found_now;
   logic out_free;
   logic list_emit;
   logic advance;
   logic last_step;
   logic full;

   krt_chain u_chain (
      .clock   (clock),
      .ctl     (chain_ctl),
      .tail_in (tail_in),
      .head    (head)
   );

   always_comb begin
      accept    = req_tvalid && (state_ff == S_IDLE);
      full      = (fill_ff >= FILL_W'(DEPTH));
      in_range  = (FILL_W'(step_ff) < fill_ff);
      hit       = (state_ff == S_WALK) && in_range && (head.key == req_ff.key) && !found_ff;
      found_now = found_ff | hit;
      out_free  = !rsp_valid_ff || rsp_tready;
      list_emit = (state_ff == S_WALK) && (op_ff == REQ_LIST) && in_range;
      advance   = (state_ff == S_WALK) && (!list_emit || out_free);
      last_step = (step_ff == IDX_W'(DEPTH - 1));

      // The record leaving cell 0 re-enters at the tail, changed where the request says.
      tail_in = head;
      if (op_ff == REQ_ADD && FILL_W'(step_ff) == fill_ff) begin
         tail_in = req_ff;
      end else if (op_ff == REQ_UPDATE && hit) begin
         tail_in.name   = req_ff.name;
         tail_in.amount = req_ff.amount;
      end

      chain_ctl.rotate  = advance;
      chain_ctl.compact = (state_ff == S_SHIFT);
      chain_ctl.gap_idx = gap_ff;

      state_in  = state_ff;
      op_in     = op_ff;
      req_in    = req_ff;
      step_in   = step_ff;
      found_in  = found_ff;
      gap_in    = gap_ff;
      status_in = status_ff;
      res_in    = res_ff;
      fill_in   = fill_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in      = req_tuser;
               req_in.key = req_tdata[31:0];
               req_in.name = req_tdata[95:32] & NAME_MASK;
               req_in.amount = req_tdata[127:96];
               step_in    = '0;
               found_in   = 1'b0;
               res_in     = '0;
               status_in  = ST_OK;
               state_in   = S_WALK;
               unique case (req_tuser)
                  REQ_ADD: begin
                     if (full) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end
                  end
                  REQ_DELETE, REQ_UPDATE, REQ_SEARCH: begin
                     state_in = S_WALK;
                  end
                  REQ_LIST: begin
                     if (fill_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (list_emit && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_rec_in    = head;
               rsp_occ_in    = OCC_W'(fill_ff);
               rsp_last_in   = (FILL_W'(step_ff) + FILL_W'(1) == fill_ff);
            end
            if (advance) begin
               step_in = step_ff + IDX_W'(1);
               if (hit) begin
                  found_in = 1'b1;
                  gap_in   = step_ff;
                  if (op_ff == REQ_SEARCH) begin
                     res_in = head;
                  end
               end
               if (last_step) begin
                  state_in  = S_DONE;
                  status_in = found_now ? ST_OK : ST_NOT_FOUND;
                  unique case (op_ff)
                     REQ_ADD: begin
                        fill_in   = fill_ff + FILL_W'(1);
                        status_in = ST_OK;
                     end
                     REQ_DELETE: begin
                        if (found_now) begin
                           state_in = S_SHIFT;
                        end
                     end
                     REQ_LIST: begin
                        state_in = S_IDLE;
                     end
                     default: begin
                        state_in = S_DONE;
                     end
                  endcase
               end
            end
         end
         S_SHIFT: begin
            fill_in   = fill_ff - FILL_W'(1);
            status_in = ST_OK;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_rec_in    = res_ff;
               rsp_occ_in    = OCC_W'(fill_ff);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      req_ff        <= req_in;
      step_ff       <= step_in;
      found_ff      <= found_in;
      gap_ff        <= gap_in;
      status_ff     <= status_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {1'b0, rsp_occ_ff, rsp_rec_ff.amount, rsp_rec_ff.name, rsp_rec_ff.key};

endmodule

// ===== rtl/krt_checker.sv =====
// Port-level checks of the keyed record table, bound to the top level.
module krt_checker import krt_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         rsp_tlast
);

   // No result is offered right after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // The table works on one request at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in progress");

   // A failed or empty result ends its request and carries no record.
   a_error_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tlast && rsp_tdata[127:0] == 128'd0)
      else $error("error result with record data or without last mark");

   // The reported occupancy never exceeds the table size.
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[134:128] <= OCC_W'(DEPTH))
      else $error("occupancy beyond table size");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind keyed_record_table krt_checker u_krt_checker (.*);
